@@ rtl/ipu_pkg.sv @@
package ipu_pkg;

  // Line buffer geometry
  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned AddrW    = $clog2(MaxWidth);
  localparam int unsigned WidthW   = 11;

  // Scale range
  localparam int unsigned MaxScale = 16;
  localparam int unsigned ScaleW   = 5;
  localparam int unsigned RowsW    = 4;

  // Result counter: up to MaxScale copies plus three pad bytes
  localparam int unsigned CntW     = 5;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = WidthW;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSourceWidth = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgScaleFactor = 1'd1;

  // Input functions
  localparam logic FuncPush = 1'b0;
  localparam logic FuncTick = 1'b1;

  // Result kinds
  localparam logic KindPixel = 1'b0;
  localparam logic KindPad   = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       row_end;
    logic       run_last;
    logic       error;
  } out_item_t;

endpackage

@@ rtl/integer_pixel_upscaler_top.sv @@
// An item is held in the job register, then each result in the output register.
// Throughput: one result per cycle when not stalled; an item holds the run emitter
//   for scale_factor results, plus 0..3 row-end pad bytes, or 1 for an error item.
// The next item is accepted in the cycle its predecessor's last result moves out.
// Reset: positions, replay count and handshake state clear; both registers read 1.
// The 1024-entry line store is not cleared; entries are valid once written.
module integer_pixel_upscaler_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ipu_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ipu_pkg::out_item_t             out_item_o,
  input  logic                           cfg_we_i,
  input  logic [ipu_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ipu_pkg::CfgDataW-1:0]   cfg_data_i
);
  import ipu_pkg::*;

  typedef struct packed {
    logic              err;
    logic              from_mem;
    logic              row_done;
    logic [23:0]       pix;
    logic [ScaleW-1:0] scale;
    logic [CntW-1:0]   last_idx;
  } job_t;

  // Configuration registers
  logic [WidthW-1:0] src_width_q;
  logic [ScaleW-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q <= WidthW'(1);
      scale_q     <= ScaleW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSourceWidth: src_width_q <= cfg_data_i;
        CfgScaleFactor: scale_q     <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // Effective width and scale, clamped to the supported range
  logic [WidthW-1:0] eff_w;
  logic [ScaleW-1:0] eff_s;
  logic [WidthW-1:0] w_m1;
  logic [5:0]        pad_prod;
  logic [1:0]        pad_n;

  always_comb begin
    if (src_width_q == '0)                       eff_w = WidthW'(1);
    else if (src_width_q > WidthW'(MaxWidth))    eff_w = WidthW'(MaxWidth);
    else                                         eff_w = src_width_q;
    if (scale_q == '0)                           eff_s = ScaleW'(1);
    else if (scale_q > ScaleW'(MaxScale))        eff_s = ScaleW'(MaxScale);
    else                                         eff_s = scale_q;
    w_m1 = eff_w - WidthW'(1);
    // Row bytes mod 4 only depends on the low two bits of width and scale
    pad_prod = {4'b0, eff_w[1:0]} * {4'b0, eff_s[1:0]} * 6'd3;
    pad_n    = 2'd0 - pad_prod[1:0];
  end

  // Position state
  logic [AddrW-1:0] col_q, col_d;
  logic [AddrW-1:0] rpos_q, rpos_d;
  logic [RowsW-1:0] rows_q, rows_d;

  // Emitter state
  logic            job_valid_q;
  job_t            job_q, job_d;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  out_item_t       out_q, out_d;

  logic acc, adv, is_last;
  logic is_push, is_err, row_done;

  assign adv        = job_valid_q && (!out_valid_q || out_ready_i);
  assign is_last    = (cnt_q == job_q.last_idx);
  assign in_ready_o = !job_valid_q || (adv && is_last);
  assign acc        = in_valid_i && in_ready_o;

  // Decode the incoming item against the current phase
  always_comb begin
    is_push = (in_item_i.func == FuncPush);
    is_err  = is_push ? (rows_q != '0) : (rows_q == '0);
    row_done = is_push ? (col_q >= w_m1[AddrW-1:0]) : (rpos_q >= w_m1[AddrW-1:0]);
    col_d  = col_q;
    rpos_d = rpos_q;
    rows_d = rows_q;
    if (!is_err) begin
      if (is_push) begin
        if (row_done) begin
          col_d  = '0;
          rpos_d = '0;
          rows_d = RowsW'(eff_s - ScaleW'(1));
        end else begin
          col_d = col_q + AddrW'(1);
        end
      end else if (row_done) begin
        rpos_d = '0;
        rows_d = rows_q - RowsW'(1);
      end else begin
        rpos_d = rpos_q + AddrW'(1);
      end
    end

    job_d.err      = is_err;
    job_d.from_mem = !is_err && !is_push;
    job_d.row_done = !is_err && row_done;
    job_d.pix      = is_err ? 24'd0
                            : {in_item_i.red_in, in_item_i.green_in, in_item_i.blue_in};
    job_d.scale    = is_err ? ScaleW'(1) : eff_s;
    job_d.last_idx = is_err ? '0
                   : CntW'(eff_s) - CntW'(1) + (job_d.row_done ? CntW'(pad_n) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      rpos_q <= '0;
      rows_q <= '0;
    end else if (acc) begin
      col_q  <= col_d;
      rpos_q <= rpos_d;
      rows_q <= rows_d;
    end
  end

  // Line store: write on push, read on tick. Pushes and ticks never share a
  // cycle, and a write is visible to any later read, so no bypass.
  logic [23:0] line_mem [MaxWidth];
  logic [23:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (acc && is_push && !is_err) line_mem[col_q] <= job_d.pix;
    if (acc && !is_push && !is_err) rd_q <= line_mem[rpos_q];
  end

  // Run emitter job register and copy counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else if (acc) begin
      job_valid_q <= 1'b1;
      cnt_q       <= '0;
    end else if (adv) begin
      if (is_last) job_valid_q <= 1'b0;
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) job_q <= job_d;
  end

  // Build the next result
  logic [23:0] run_pix;
  logic        pad_slot;

  always_comb begin
    run_pix  = job_q.from_mem ? rd_q : job_q.pix;
    pad_slot = (cnt_q >= CntW'(job_q.scale));
    out_d.kind      = pad_slot ? KindPad : KindPixel;
    out_d.blue_out  = pad_slot ? 8'd0 : run_pix[7:0];
    out_d.green_out = pad_slot ? 8'd0 : run_pix[15:8];
    out_d.red_out   = pad_slot ? 8'd0 : run_pix[23:16];
    out_d.row_end   = is_last && job_q.row_done;
    out_d.run_last  = is_last;
    out_d.error     = job_q.err;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  a_accept_only_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && job_valid_q) |-> (adv && is_last))
    else $error("item accepted while run still busy");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (cnt_q <= job_q.last_idx))
    else $error("copy counter ran past end of run");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.error) |-> (out_item_o.run_last && !out_item_o.row_end))
    else $error("error item not a single result");

  a_row_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.row_end) |-> out_item_o.run_last)
    else $error("row end before end of run");

  a_rows_after_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !is_err && is_push && row_done) |=> (rows_q == RowsW'($past(eff_s) - 1'b1)))
    else $error("replay count not armed at row end");

endmodule
